### rtl/core/mpw_pkg.sv
// Package for the medical pixel window to 8-bit core.
// Register indexes, the configuration bundle type and shared constants; no dependencies.
package mpw_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 32;

	localparam logic [CFG_IDX_W-1:0] REG_IS_SIGNED  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_BIT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLOPE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTERCEPT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 3'd5;

	localparam logic [7:0] GRAY_MAX = 8'd255;

	typedef struct packed {
		logic               is_signed;
		logic [3:0]         high_bit;
		logic signed [31:0] slope;
		logic signed [31:0] intercept;
		logic signed [31:0] center;
		logic [31:0]        width;
	} cfg_t;

endpackage

### rtl/core/mpw_fifo.sv
// Short register queue between the front and back parts.
// Depends on nothing.
module mpw_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en && !full) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en && !full) begin
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (rd_en && !empty) begin
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && !empty);
		end
	end
endmodule

### rtl/core/mpw_front.sv
// Front part: clip, rescale, range tracking and setup of the divide job.
// Depends on mpw_pkg.
module mpw_front import mpw_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int NW = 43,
	parameter int DW = 33
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                push,
	output logic                full,
	input  logic [15:0]         pixel_word,
	input  logic                mode,
	input  logic                first_of_frame,
	output logic                job_valid,
	output logic [NW+DW:0]      job_data,
	input  logic                job_full
);
	localparam int VW = 16 + FRAC_BITS;
	localparam int PW = 49;

	logic        stall;
	logic        v_s1, v_s2, v_s3, v_s4;
	logic [15:0] w_s1;
	logic        m_s1, m_s2, m_s3, f_s1, f_s2, f_s3;
	logic signed [47:0] prod_s2;
	logic signed [15:0] val_s3;
	logic [NW+DW:0]     job_s4;
	logic signed [15:0] min_q, max_q;

	logic [15:0] keep, clip_w;
	logic signed [PW-1:0] p_sum, p_adj, p_shr;
	logic signed [15:0]   val_sat;
	logic signed [VW-1:0] vf;
	logic signed [NW-1:0] diff, n2;
	logic signed [16:0]   dv, span;
	logic [NW+DW:0]       job_c;

	assign stall     = v_s4 && job_full;
	assign full      = stall;
	assign job_valid = v_s4;
	assign job_data  = job_s4;

	// Mask above high bit, or copy the high bit upward when signed
	always_comb begin
		keep = 16'hFFFF >> (4'd15 - cfg.high_bit);
		if (cfg.is_signed && pixel_word[cfg.high_bit]) begin
			clip_w = pixel_word | ~keep;
		end else begin
			clip_w = pixel_word & keep;
		end
	end

	// Truncate toward zero, then saturate
	always_comb begin
		p_sum = PW'(prod_s2) + PW'(cfg.intercept);
		p_adj = p_sum[PW-1] ? p_sum + PW'((64'd1 << FRAC_BITS) - 64'd1) : p_sum;
		p_shr = p_adj >>> FRAC_BITS;
		if (p_shr > PW'(32767)) begin
			val_sat = 16'sh7FFF;
		end else if (p_shr < -PW'(32768)) begin
			val_sat = -16'sh8000;
		end else begin
			val_sat = p_shr[15:0];
		end
	end

	// Job layout: mul255 flag, denominator, numerator
	always_comb begin
		vf   = VW'(val_s3) <<< FRAC_BITS;
		diff = NW'(vf) - NW'(cfg.center);
		n2   = (diff <<< 1) + NW'({1'b0, cfg.width});
		dv   = 17'(val_s3) - 17'(min_q);
		span = 17'(max_q) - 17'(min_q);
		if (cfg.center != '0 || cfg.width != '0) begin
			if (cfg.width == '0) begin
				job_c = {1'b0, DW'(1), (diff >= 0) ? NW'(255) : NW'(0)};
			end else begin
				job_c = {1'b1, DW'({cfg.width, 1'b0}), n2};
			end
		end else if (span > 0) begin
			job_c = {1'b1, DW'(span[15:0]), NW'(dv)};
		end else begin
			job_c = {1'b0, DW'(1), NW'(dv)};
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			w_s1    <= clip_w;
			m_s1    <= mode;
			f_s1    <= first_of_frame;
			prod_s2 <= 48'(signed'(w_s1)) * 48'(cfg.slope);
			m_s2    <= m_s1;
			f_s2    <= f_s1;
			val_s3  <= val_sat;
			m_s3    <= m_s2;
			f_s3    <= f_s2;
			job_s4  <= job_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			min_q <= '0;
			max_q <= '0;
		end else if (!stall) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3 && !m_s3;
			if (v_s3 && m_s3) begin
				if (f_s3 || val_s3 < min_q) begin
					min_q <= val_s3;
				end
				if (f_s3 || val_s3 > max_q) begin
					max_q <= val_s3;
				end
			end
		end
	end
endmodule

### rtl/core/mpw_back.sv
// Back part: clamped divide to a gray level and the result register.
// Depends on mpw_pkg.
module mpw_back import mpw_pkg::*; #(
	parameter int NW = 43,
	parameter int DW = 33
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_empty,
	input  logic [NW+DW:0] job_data,
	output logic           job_pop,
	input  logic           pop,
	output logic           empty,
	output logic [7:0]     gray_level
);
	localparam int RW = NW + 10;
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CHK  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]          st_q;
	logic signed [RW-1:0] rem_q, dsh_q, den_q, trial, n_in;
	logic [2:0]          k_q;
	logic [7:0]          g_q, out_q;
	logic                out_v_q;

	assign empty      = !out_v_q;
	assign gray_level = out_q;
	assign job_pop    = (st_q == ST_IDLE) && !job_empty;
	assign n_in       = RW'(signed'(job_data[NW-1:0]));
	assign trial      = rem_q - dsh_q;

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				rem_q <= job_data[NW+DW] ? (n_in <<< 8) - n_in : n_in;
				den_q <= RW'(job_data[NW+DW-1:NW]);
			end
			ST_CHK: begin
				dsh_q <= den_q <<< 7;
				k_q   <= 3'd7;
				if (rem_q <= 0) begin
					g_q <= '0;
				end else if (rem_q >= (den_q <<< 8)) begin
					g_q <= GRAY_MAX;
				end else begin
					g_q <= '0;
				end
			end
			ST_DIV: begin
				if (trial >= 0) begin
					rem_q    <= trial;
					g_q[k_q] <= 1'b1;
				end
				dsh_q <= dsh_q >>> 1;
				k_q   <= k_q - 1'b1;
			end
			default: begin
				if (!out_v_q || pop) begin
					out_q <= g_q;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			out_v_q <= 1'b0;
		end else begin
			if (pop && out_v_q) begin
				out_v_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (!job_empty) begin
						st_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (rem_q <= 0 || rem_q >= (den_q <<< 8)) begin
						st_q <= ST_DONE;
					end else begin
						st_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (k_q == 3'd0) begin
						st_q <= ST_DONE;
					end
				end
				default: begin
					// hold until the result register frees up
					if (!out_v_q || pop) begin
						out_v_q <= 1'b1;
						st_q    <= ST_IDLE;
					end
				end
			endcase
		end
	end
endmodule

### rtl/core/medical_pixel_window_to_8bit_core.sv
// Top level of the medical pixel window to 8-bit core.
// Depends on mpw_pkg, mpw_front, mpw_fifo and mpw_back.
//
// Pixels enter through a push/full queue port; map items (mode 0) give one gray level each
// through an empty/pop queue port, measure items (mode 1) only update the auto range. The
// front part takes one pixel per cycle, unless a full job queue stalls it, through a
// four-stage pipeline (clip, 16x32 rescale multiply, round and saturate, job setup).
// The back part runs a restoring divider that makes one quotient bit per cycle and takes
// a new job only when idle; a map item skips the divide when the scaled numerator is not
// positive or the quotient would exceed 255. Measure items stream at one per cycle unless
// the front stalls; a four-entry job queue lets it run ahead. The user must write
// configuration (cfg_we, cfg_idx, cfg_data) while idle; the block does not enforce it.
module medical_pixel_window_to_8bit_core import mpw_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  push,
	output logic                  full,
	input  logic [15:0]           pixel_word,
	input  logic                  mode,
	input  logic                  first_of_frame,
	output logic                  empty,
	input  logic                  pop,
	output logic [7:0]            gray_level
);
	localparam int VW = 16 + FRAC_BITS;
	localparam int NW = ((VW > 32) ? VW : 32) + 3;
	localparam int DW = 33;
	localparam int JW = NW + DW + 1;

	cfg_t          cfg_q;
	logic          job_valid, job_full, job_empty, job_pop;
	logic [JW-1:0] job_in, job_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.is_signed <= 1'b0;
			cfg_q.high_bit  <= 4'd15;
			cfg_q.slope     <= 32'sd1 <<< FRAC_BITS;
			cfg_q.intercept <= '0;
			cfg_q.center    <= '0;
			cfg_q.width     <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_IS_SIGNED: cfg_q.is_signed <= cfg_data[0];
				REG_HIGH_BIT:  cfg_q.high_bit  <= cfg_data[3:0];
				REG_SLOPE:     cfg_q.slope     <= cfg_data;
				REG_INTERCEPT: cfg_q.intercept <= cfg_data;
				REG_CENTER:    cfg_q.center    <= cfg_data;
				REG_WIDTH:     cfg_q.width     <= cfg_data;
				default: ;
			endcase
		end
	end

	mpw_front #(.FRAC_BITS(FRAC_BITS), .NW(NW), .DW(DW)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.push(push), .full(full), .pixel_word(pixel_word), .mode(mode),
		.first_of_frame(first_of_frame),
		.job_valid(job_valid), .job_data(job_in), .job_full(job_full)
	);

	mpw_fifo #(.W(JW), .DEPTH(4)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_en(job_valid), .wr_data(job_in), .full(job_full),
		.rd_en(job_pop), .rd_data(job_out), .empty(job_empty)
	);

	mpw_back #(.NW(NW), .DW(DW)) u_back (
		.clk(clk), .arst_n(arst_n),
		.job_empty(job_empty), .job_data(job_out), .job_pop(job_pop),
		.pop(pop), .empty(empty), .gray_level(gray_level)
	);
endmodule

### tb/tb_medical_pixel_window_to_8bit_core.sv
// Testbench for medical_pixel_window_to_8bit_core: queued pixel items, predicted gray levels.
// Depends on mpw_pkg and the core; the predictor is a fixed-point model of clip, rescale,
// window and auto range.
`timescale 1ns / 100ps

module tb_medical_pixel_window_to_8bit_core;
	import mpw_pkg::*;

	localparam int  FRAC       = 16;
	localparam int  SETTLE     = 40;
	localparam int  CYCLE_MAX  = 500000;
	localparam int  HOLD_LEN   = 300;
	localparam int  HOLD_AT    = 700;

	typedef struct {
		logic [15:0] word;
		logic        measure;
		logic        first;
	} pixel_item_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = REG_IS_SIGNED;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  push = 1'b0;
	logic                  full;
	logic [15:0]           pixel_word = '0;
	logic                  mode = 1'b0;
	logic                  first_of_frame = 1'b0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic [7:0]            gray_level;

	cfg_t              cfg;
	logic signed [15:0] lo_seen, hi_seen;
	pixel_item_t       pixel_q[$];
	pixel_item_t       cur_item;
	logic [7:0]        gray_expected[$];
	int                n_accepted = 0;
	int                n_errors = 0;
	int                n_mismatch = 0;
	int                cyc = 0;
	int                hold_left = 0;
	bit                hold_done = 1'b0;
	bit                quiet;

	medical_pixel_window_to_8bit_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.push(push), .full(full),
		.pixel_word(pixel_word), .mode(mode), .first_of_frame(first_of_frame),
		.empty(empty), .pop(pop), .gray_level(gray_level)
	);

	always #6 clk = ~clk;

	// no idling while this stretch of items goes through
	assign quiet = (n_accepted >= 1000) && (n_accepted < 1300);

	function automatic logic signed [15:0] rescale_pixel(logic [15:0] w);
		logic [15:0] keep;
		longint      p, r;
		if (cfg.high_bit != 4'd15) begin
			keep = 16'((32'd1 << (int'(cfg.high_bit) + 1)) - 1);
			if (cfg.is_signed && w[cfg.high_bit])
				w = w | ~keep;
			else
				w = w & keep;
		end
		p = longint'($signed(w)) * longint'(cfg.slope) + longint'(cfg.intercept);
		r = p / (longint'(1) << FRAC);
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return 16'(r);
	endfunction

	function automatic logic [7:0] clamp_gray(longint n, longint d);
		longint q;
		if (n <= 0) return 8'd0;
		q = n / d;
		return (q > 255) ? GRAY_MAX : 8'(q);
	endfunction

	// advance the range on a measure item, queue the gray level on a map item
	task automatic predict_item(pixel_item_t it);
		logic signed [15:0] v;
		longint vf, c, wd, d;
		v = rescale_pixel(it.word);
		if (it.measure) begin
			if (it.first) begin
				lo_seen = v;
				hi_seen = v;
			end else begin
				if (v < lo_seen) lo_seen = v;
				if (v > hi_seen) hi_seen = v;
			end
		end else if (cfg.center != 0 || cfg.width != 0) begin
			vf = longint'(v) <<< FRAC;
			c  = longint'(cfg.center);
			wd = longint'({32'd0, cfg.width});
			if (wd == 0)
				gray_expected.push_back((vf >= c) ? GRAY_MAX : 8'd0);
			else
				gray_expected.push_back(clamp_gray((2 * vf - 2 * c + wd) * 255, 2 * wd));
		end else begin
			d = longint'(v) - longint'(lo_seen);
			if (hi_seen > lo_seen)
				gray_expected.push_back(clamp_gray(d * 255, longint'(hi_seen) - lo_seen));
			else
				gray_expected.push_back(clamp_gray(d, 1));
		end
	endtask

	// input side: hold while full, otherwise offer the next pending item or idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				predict_item(cur_item);
				n_accepted++;
			end
			if (!(push && full)) begin
				if (pixel_q.size() > 0 && (quiet || $urandom_range(99) >= 14)) begin
					cur_item = pixel_q.pop_front();
					push <= 1'b1;
					pixel_word <= cur_item.word;
					mode <= cur_item.measure;
					first_of_frame <= cur_item.first;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off so the block fills up and stalls its input
	always @(posedge clk) begin
		if (!hold_done && n_accepted >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_LEN;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// result side
	always @(posedge clk) begin
		logic [7:0] e;
		if (arst_n) begin
			if (pop && !empty) begin
				if (gray_expected.size() == 0) begin
					n_errors++;
					$display("unexpected gray level %0d", gray_level);
				end else begin
					e = gray_expected.pop_front();
					if (gray_level !== e) begin
						n_errors++;
						n_mismatch++;
						if (n_mismatch <= 10)
							$display("gray_level mismatch: expected %0d, got %0d", e, gray_level);
					end
				end
			end
			pop <= (hold_left == 0) && (quiet || $urandom_range(99) >= 14);
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CYCLE_MAX) begin
			$display("** medical_pixel_window_to_8bit_core: FAILED **");
			$finish;
		end
	end

	task automatic add_item(logic [15:0] w, logic meas, logic fst);
		pixel_item_t it;
		it.word = w;
		it.measure = meas;
		it.first = fst;
		pixel_q.push_back(it);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
	endtask

	task automatic set_cfg(logic sgn, logic [3:0] hb, logic [31:0] slope, logic [31:0] icpt,
			logic [31:0] ctr, logic [31:0] wid);
		write_reg(REG_IS_SIGNED, {31'd0, sgn});
		write_reg(REG_HIGH_BIT, {28'd0, hb});
		write_reg(REG_SLOPE, slope);
		write_reg(REG_INTERCEPT, icpt);
		write_reg(REG_CENTER, ctr);
		write_reg(REG_WIDTH, wid);
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg.is_signed = sgn;
		cfg.high_bit = hb;
		cfg.slope = slope;
		cfg.intercept = icpt;
		cfg.center = ctr;
		cfg.width = wid;
	endtask

	task automatic drain();
		while (pixel_q.size() > 0 || push || gray_expected.size() > 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	function automatic logic [15:0] rand_word();
		case ($urandom_range(5))
			0: return 16'($urandom_range(15));
			1: return 16'hffff - 16'($urandom_range(15));
			2: return 16'h8000 ^ 16'($urandom_range(31));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic gen_items(int n);
		int cnt, k;
		cnt = 0;
		while (cnt < n) begin
			if ($urandom_range(9) < 7) begin
				// frame: reload the range, widen it, then map
				add_item(rand_word(), 1'b1, 1'b1);
				k = $urandom_range(6);
				repeat (k) add_item(rand_word(), 1'b1, 1'b0);
				cnt += k + 1;
				k = $urandom_range(10, 1);
				repeat (k) add_item(rand_word(), 1'b0, 1'($urandom_range(1)));
				cnt += k;
			end else begin
				add_item(16'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
				cnt++;
			end
		end
	endtask

	initial begin
		logic [31:0] slope, icpt, ctr, wid;
		cfg = '{is_signed: 1'b0, high_bit: 4'd15, slope: 32'sd65536, intercept: 32'sd0,
			center: 32'sd0, width: 32'd0};
		lo_seen = '0;
		hi_seen = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: auto map before any measure, then extreme and flat ranges
		add_item(16'h0000, 1'b0, 1'b0);
		add_item(16'h0001, 1'b0, 1'b1);
		add_item(16'hffff, 1'b0, 1'b0);
		add_item(16'h8000, 1'b1, 1'b1);
		add_item(16'h7fff, 1'b1, 1'b0);
		add_item(16'h8000, 1'b0, 1'b0);
		add_item(16'h7fff, 1'b0, 1'b0);
		add_item(16'h0000, 1'b0, 1'b0);
		add_item(16'h0005, 1'b1, 1'b1);
		add_item(16'h0004, 1'b0, 1'b0);
		add_item(16'h0005, 1'b0, 1'b0);
		add_item(16'h0105, 1'b0, 1'b0);
		add_item(16'h0010, 1'b1, 1'b0);
		add_item(16'h000a, 1'b0, 1'b0);
		add_item(16'hfff0, 1'b1, 1'b0);
		add_item(16'h0000, 1'b0, 1'b0);
		drain();

		for (int p = 0; p < 12; p++) begin
			case (p)
				0: set_cfg(1'b0, 4'd15, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
				1: set_cfg(1'b1, 4'd11, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
				2: set_cfg(1'b0, 4'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff);
				3: set_cfg(1'b1, 4'd0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
				4: set_cfg(1'b1, 4'd15, 32'h0001_0000, 32'h0, 32'h7fff_ffff, 32'h0);
				5: set_cfg(1'b1, 4'd7, 32'h0, 32'($urandom), 32'h0, 32'h0);
				6: set_cfg(1'b0, 4'd15, 32'h0001_0000, 32'h0, 32'h0000_0000, 32'h0000_0001);
				default: begin
					slope = 32'($urandom_range(1 << 19)) - 32'(1 << 18);
					icpt = 32'($signed($urandom) >>> $urandom_range(31, 1));
					ctr = 32'($signed($urandom) >>> $urandom_range(31, 1));
					wid = $urandom >> $urandom_range(31, 4);
					if ($urandom_range(3) == 0) begin
						ctr = 32'h0;
						wid = 32'h0;
					end
					set_cfg(1'($urandom_range(1)), 4'($urandom_range(15)), slope, icpt, ctr, wid);
				end
			endcase
			gen_items(150);
			drain();
		end

		if (n_errors == 0)
			$display("** medical_pixel_window_to_8bit_core: PASSED **");
		else
			$display("** medical_pixel_window_to_8bit_core: FAILED **");
		$finish;
	end

endmodule

### medical_pixel_window_to_8bit_core.f
rtl/core/mpw_pkg.sv
rtl/core/mpw_fifo.sv
rtl/core/mpw_front.sv
rtl/core/mpw_back.sv
rtl/core/medical_pixel_window_to_8bit_core.sv
tb/tb_medical_pixel_window_to_8bit_core.sv
